FILE: hw/rtl/ctrs_pkg.sv
// Shared types and codes for the closest-ticket ready scheduler.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package ctrs_pkg;

	// Operation codes
	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_DISPATCH = 2'd1;
	localparam logic [1:0] OP_REMOVE   = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // latch a new item, reset the scan
		logic issue;   // read the slot at the scan counter, advance
		logic commit;  // apply the table update, load the result register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_issue;  // scan counter is at the final slot
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/closest_ticket_ready_scheduler.sv
// Closest-ticket ready scheduler, top level: controller plus datapath.
// Depends on ctrs_pkg, ctrs_ctrl and ctrs_datapath.
// One item at a time: in_ready stays low from input transfer until the result is committed.
// The slot scan reads one table entry per cycle through a single memory read port.
// Reset (arst_n low, asynchronous) clears all valid bits, leaving the table empty.
`default_nettype none

module closest_ticket_ready_scheduler import ctrs_pkg::*; #(
	parameter int READY_SLOTS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Input channel: one operation per transfer
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] operation,
	input  wire logic [7:0] thread_id,
	input  wire logic [7:0] thread_ticket,
	input  wire logic [7:0] lucky_number,
	// Result channel: one result per operation
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] chosen_id,
	output logic      [7:0] chosen_ticket,
	output logic      [1:0] status
);

	// Commands flow from the sequencer to the datapath; the datapath
	// reports back only when the scan reaches the last slot.
	cmd_t     cmd;
	dp_stat_t st;

	// Sequencer: hold in_ready low from transfer until the result is
	// committed, scan every slot, drain the read stage, then commit
	// once the result register is free.
	ctrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: slot table, first-free / first-match / closest-ticket
	// selection during the scan, and the registered result.
	ctrs_datapath #(
		.READY_SLOTS (READY_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.operation     (operation),
		.thread_id     (thread_id),
		.thread_ticket (thread_ticket),
		.lucky_number  (lucky_number),
		.chosen_id     (chosen_id),
		.chosen_ticket (chosen_ticket),
		.status        (status)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/ctrs_ctrl.sv
// Sequencer for the closest-ticket ready scheduler: accept, scan, drain, commit.
// Depends on ctrs_pkg for the command and status structs.
`default_nettype none

module ctrs_ctrl import ctrs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t st,
	output cmd_t          cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_commit;

	assign can_commit = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.issue  = (state_q == S_SCAN);
		cmd.commit = (state_q == S_DONE) && can_commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (st.last_issue) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (can_commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_scan_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !st.last_issue) |=> (state_q == S_SCAN))
		else $error("scan left before the last slot");
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit while result register is still full");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a second item while busy");

endmodule

`default_nettype wire

FILE: hw/rtl/ctrs_datapath.sv
// Slot table, scan compare and result register of the closest-ticket scheduler.
// Depends on ctrs_pkg for op/status codes and the command and status structs.
`default_nettype none

module ctrs_datapath import ctrs_pkg::*; #(
	parameter int READY_SLOTS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	output dp_stat_t        st,
	input  wire logic [1:0] operation,
	input  wire logic [7:0] thread_id,
	input  wire logic [7:0] thread_ticket,
	input  wire logic [7:0] lucky_number,
	output logic      [7:0] chosen_id,
	output logic      [7:0] chosen_ticket,
	output logic      [1:0] status
);

	localparam int SLOT_W = $clog2(READY_SLOTS);

	// Table storage: valid bits in flops, id and ticket in memory
	logic [READY_SLOTS-1:0] valid_q;
	logic [7:0]             thread_mem [READY_SLOTS];
	logic [7:0]             ticket_mem [READY_SLOTS];

	// Latched item
	logic [1:0] op_q;
	logic [7:0] id_q;
	logic [7:0] tkt_q;
	logic [7:0] lucky_q;

	// Scan
	logic [SLOT_W-1:0] cnt_q;
	logic              act_s1;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [7:0]        rd_thread_s1;
	logic [7:0]        rd_ticket_s1;

	// Best candidate so far
	logic              found_q;
	logic [SLOT_W-1:0] pick_q;
	logic [7:0]        best_dist_q;
	logic [7:0]        best_thread_q;
	logic [7:0]        best_ticket_q;

	// Result register
	logic [7:0] chosen_id_q;
	logic [7:0] chosen_ticket_q;
	logic [1:0] status_q;

	logic [7:0] gap;
	logic       take;

	// Next result, loaded on commit
	logic [7:0] res_id;
	logic [7:0] res_ticket;
	logic [1:0] res_status;

	assign st.last_issue = (cnt_q == SLOT_W'(READY_SLOTS - 1));

	always_comb begin
		gap = (rd_ticket_s1 >= lucky_q) ? (rd_ticket_s1 - lucky_q) : (lucky_q - rd_ticket_s1);
		take = 1'b0;
		case (op_q)
			OP_ADD:      take = !vld_s1 && !found_q;
			OP_REMOVE:   take = vld_s1 && (rd_thread_s1 == id_q) && !found_q;
			OP_DISPATCH: take = vld_s1 && (!found_q || (gap < best_dist_q) ||
			                   ((gap == best_dist_q) && (rd_thread_s1 < best_thread_q)));
			default:     take = 1'b0;
		endcase
	end

	always_comb begin
		res_id     = 8'd0;
		res_ticket = 8'd0;
		res_status = ST_OK;
		case (op_q)
			OP_ADD:    if (!found_q) res_status = ST_FULL;
			OP_REMOVE: if (!found_q) res_status = ST_NOT_FOUND;
			OP_DISPATCH: begin
				if (found_q) begin
					res_id     = best_thread_q;
					res_ticket = best_ticket_q;
				end else begin
					res_status = ST_EMPTY;
				end
			end
			default: res_status = ST_OK;
		endcase
	end

	// Control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			act_s1  <= 1'b0;
			found_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			act_s1 <= cmd.issue;
			if (cmd.load) begin
				found_q <= 1'b0;
				cnt_q   <= '0;
			end else begin
				if (cmd.issue) cnt_q <= cnt_q + 1'b1;
				if (act_s1 && take) found_q <= 1'b1;
			end
			if (cmd.commit && found_q) begin
				if (op_q == OP_ADD) valid_q[pick_q] <= 1'b1;
				else if (op_q == OP_REMOVE || op_q == OP_DISPATCH) valid_q[pick_q] <= 1'b0;
			end
		end
	end

	// Payload registers and memories
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			id_q    <= thread_id;
			tkt_q   <= thread_ticket;
			lucky_q <= lucky_number;
		end
		if (cmd.issue) begin
			vld_s1       <= valid_q[cnt_q];
			idx_s1       <= cnt_q;
			rd_thread_s1 <= thread_mem[cnt_q];
			rd_ticket_s1 <= ticket_mem[cnt_q];
		end
		if (act_s1 && take) begin
			pick_q        <= idx_s1;
			best_dist_q   <= gap;
			best_thread_q <= rd_thread_s1;
			best_ticket_q <= rd_ticket_s1;
		end
		if (cmd.commit && found_q && op_q == OP_ADD) begin
			thread_mem[pick_q] <= id_q;
			ticket_mem[pick_q] <= tkt_q;
		end
		if (cmd.commit) begin
			chosen_id_q     <= res_id;
			chosen_ticket_q <= res_ticket;
			status_q        <= res_status;
		end
	end

	assign chosen_id     = chosen_id_q;
	assign chosen_ticket = chosen_ticket_q;
	assign status        = status_q;

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !act_s1)
		else $error("commit before the scan pipeline drained");
	a_full_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q != OP_ADD) |=> (status_q != ST_FULL))
		else $error("full reported for an operation other than add");
	a_add_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == OP_ADD && found_q) |=> valid_q[pick_q])
		else $error("added slot not marked valid");

endmodule

`default_nettype wire

FILE: tb/closest_ticket_ready_scheduler_checker.sv
`timescale 1ns / 1ps
// Checker for the closest-ticket ready scheduler: watches both channels,
// predicts each result from its own copy of the ready table and compares.
// Depends on ctrs_pkg for operation and status codes.

module ctrs_result_checker import ctrs_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] thread_id,
	input  logic [7:0] thread_ticket,
	input  logic [7:0] lucky_number,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] chosen_id,
	input  logic [7:0] chosen_ticket,
	input  logic [1:0] status,
	output int         pending,
	output int         fail_count
);

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] ticket;
		logic [1:0] code;
	} sched_result_t;

	bit            slot_used [SLOTS];
	logic [7:0]    slot_tid  [SLOTS];
	logic [7:0]    slot_tkt  [SLOTS];
	sched_result_t awaited_results[$];
	sched_result_t got;
	sched_result_t want;

	initial begin
		pending    = 0;
		fail_count = 0;
	end

	// Apply one operation to the shadow table and return the result it yields.
	function automatic sched_result_t apply_operation(input logic [1:0] op,
			input logic [7:0] tid, input logic [7:0] tkt, input logic [7:0] lucky);
		sched_result_t r;
		int best;
		int gap;
		int pick;
		bit hit;
		r    = '{8'd0, 8'd0, ST_OK};
		best = 256;
		pick = 0;
		hit  = 1'b0;
		case (op)
			OP_ADD: begin
				r.code = ST_FULL;
				for (int s = 0; s < SLOTS; s++) begin
					if (!slot_used[s]) begin
						slot_used[s] = 1'b1;
						slot_tid[s]  = tid;
						slot_tkt[s]  = tkt;
						r.code       = ST_OK;
						break;
					end
				end
			end
			OP_REMOVE: begin
				r.code = ST_NOT_FOUND;
				for (int s = 0; s < SLOTS; s++) begin
					if (slot_used[s] && slot_tid[s] == tid) begin
						slot_used[s] = 1'b0;
						r.code       = ST_OK;
						break;
					end
				end
			end
			OP_DISPATCH: begin
				for (int s = 0; s < SLOTS; s++) begin
					if (slot_used[s]) begin
						gap = int'((slot_tkt[s] >= lucky) ?
							(slot_tkt[s] - lucky) : (lucky - slot_tkt[s]));
						if (gap < best) begin
							best = gap;
							pick = s;
							hit  = 1'b1;
						end else if (hit && gap == best && slot_tid[s] < slot_tid[pick]) begin
							pick = s;
						end
					end
				end
				if (hit) begin
					r.id            = slot_tid[pick];
					r.ticket        = slot_tkt[pick];
					slot_used[pick] = 1'b0;
				end else begin
					r.code = ST_EMPTY;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (slot_used[s])
				slot_used[s] = 1'b0;
			awaited_results.delete();
			pending = 0;
		end else begin
			if (in_valid && in_ready)
				awaited_results.push_back(apply_operation(operation, thread_id,
					thread_ticket, lucky_number));
			if (out_valid && out_ready) begin
				got = '{chosen_id, chosen_ticket, status};
				if (awaited_results.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, %s %0d %0d %0d",
						$time, "got id/ticket/status", got.id, got.ticket, got.code);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						$display("%0t ns: result mismatch, expected id %0d ticket %0d status %0d,",
							$time, want.id, want.ticket, want.code);
						$display("    got id %0d ticket %0d status %0d",
							got.id, got.ticket, got.code);
						fail_count++;
					end
				end
			end
			pending = awaited_results.size();
		end
	end

endmodule

FILE: tb/closest_ticket_ready_scheduler_tb.sv
`timescale 1ns / 1ps
// Testbench top for closest_ticket_ready_scheduler: drives directed and random
// operations under several idling mixes; ctrs_result_checker does the checking.
// Depends on ctrs_pkg, the scheduler RTL and tb/closest_ticket_ready_scheduler_checker.sv.

module closest_ticket_ready_scheduler_tb;
	import ctrs_pkg::*;

	localparam int SLOTS           = 32;
	localparam int ITEMS_PER_PHASE = 460;
	localparam int REGIME_LEN      = 60;
	// Leave some margin after the last result.
	localparam int SETTLE_CYCLES   = SLOTS + 10;
	localparam int CYCLE_LIMIT     = 1000000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] operation = OP_ADD;
	logic [7:0] thread_id = 8'd0;
	logic [7:0] thread_ticket = 8'd0;
	logic [7:0] lucky_number = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] chosen_id;
	logic [7:0] chosen_ticket;
	logic [1:0] status;

	int pending;
	int fail_count;
	int send_idle  = 0;   // percent of cycles the sender holds off
	int recv_stall = 0;   // percent of cycles the receiver drops ready
	int cycle_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	closest_ticket_ready_scheduler #(
		.READY_SLOTS(SLOTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.thread_id    (thread_id),
		.thread_ticket(thread_ticket),
		.lucky_number (lucky_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chosen_id    (chosen_id),
		.chosen_ticket(chosen_ticket),
		.status       (status)
	);

	ctrs_result_checker #(
		.SLOTS(SLOTS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.thread_id    (thread_id),
		.thread_ticket(thread_ticket),
		.lucky_number (lucky_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chosen_id    (chosen_id),
		.chosen_ticket(chosen_ticket),
		.status       (status),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	// Receiver: drop ready at random, one decision per falling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Present one operation and hold it until the transfer completes.
	// Entered and left at a falling edge; valid stays high on exit so that
	// back-to-back transfers never see valid dip within one step.
	task automatic send_item(input logic [1:0] op, input logic [7:0] tid,
			input logic [7:0] tkt, input logic [7:0] lucky);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		operation     <= op;
		thread_id     <= tid;
		thread_ticket <= tkt;
		lucky_number  <= lucky;
		in_valid      <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Hold off the sender until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int regime;
		int roll;
		int add_pct;
		int dispatch_pct;
		logic [1:0] op;
		logic [7:0] tid;
		logic [7:0] tkt;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty table, field extremes, ties, duplicate ids.
		send_item(OP_DISPATCH, 8'd0,   8'd0,   8'd0);    // empty table
		send_item(OP_REMOVE,   8'd0,   8'd0,   8'd0);    // id not found
		send_item(OP_ADD,      8'd0,   8'd0,   8'd0);
		send_item(OP_ADD,      8'd255, 8'd254, 8'd0);
		send_item(OP_DISPATCH, 8'd0,   8'd0,   8'd254);  // exact hit at the top
		send_item(OP_DISPATCH, 8'd0,   8'd0,   8'd254);  // widest distance
		send_item(OP_ADD,      8'd7,   8'd10,  8'd0);
		send_item(OP_ADD,      8'd3,   8'd20,  8'd0);
		send_item(OP_DISPATCH, 8'd0,   8'd0,   8'd15);   // equal distance, smaller id wins
		send_item(OP_DISPATCH, 8'd0,   8'd0,   8'd200);
		send_item(OP_ADD,      8'd5,   8'd10,  8'd0);
		send_item(OP_ADD,      8'd5,   8'd20,  8'd0);
		send_item(OP_DISPATCH, 8'd0,   8'd0,   8'd15);   // equal distance and id, lower slot
		send_item(OP_DISPATCH, 8'd0,   8'd0,   8'd0);
		send_item(OP_ADD,      8'd9,   8'd1,   8'd0);
		send_item(OP_ADD,      8'd9,   8'd2,   8'd0);
		send_item(OP_REMOVE,   8'd9,   8'd0,   8'd0);    // duplicate id, lowest slot goes
		send_item(OP_DISPATCH, 8'd0,   8'd0,   8'd0);
		send_item(OP_REMOVE,   8'd9,   8'd0,   8'd0);
		send_item(OP_ADD,      8'd170, 8'd85,  8'd0);
		send_item(OP_ADD,      8'd85,  8'd170, 8'd0);
		send_item(OP_REMOVE,   8'd85,  8'd0,   8'd0);
		send_item(OP_DISPATCH, 8'd0,   8'd0,   8'd127);
		drain_results();

		// Random: four idling mixes, each drained before the next starts.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 57; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 57; end
				default: begin send_idle = 16; recv_stall = 16; end
			endcase
			regime = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Switch between filling, draining and mixed traffic so the
				// table sweeps from empty to full and back.
				if (n % REGIME_LEN == 0)
					regime = $urandom_range(2);
				case (regime)
					0: begin add_pct = 75; dispatch_pct = 15; end
					1: begin add_pct = 20; dispatch_pct = 45; end
					default: begin add_pct = 40; dispatch_pct = 35; end
				endcase
				roll = $urandom_range(99);
				if (roll < add_pct)
					op = OP_ADD;
				else if (roll < add_pct + dispatch_pct)
					op = OP_DISPATCH;
				else
					op = OP_REMOVE;
				// Mostly a small id pool so removes hit and duplicates occur.
				tid = 8'(($urandom_range(99) < 80) ?
					$urandom_range(15) : $urandom_range(255));
				// Half the tickets in a narrow band to force distance ties.
				tkt = 8'(($urandom_range(1) == 0) ?
					$urandom_range(107, 100) : $urandom_range(254));
				send_item(op, tid, tkt, 8'($urandom_range(254)));
			end
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: closest_ticket_ready_scheduler.f
hw/rtl/ctrs_pkg.sv
hw/rtl/ctrs_ctrl.sv
hw/rtl/ctrs_datapath.sv
hw/rtl/closest_ticket_ready_scheduler.sv
tb/closest_ticket_ready_scheduler_checker.sv
tb/closest_ticket_ready_scheduler_tb.sv
